// File: src/alist_pkg.sv
// ----------------------------------------------------------------------------
// alist_pkg
// Types and codes shared by the array list engine modules.
// ----------------------------------------------------------------------------
package alist_pkg;

  localparam logic [3:0] MODE_GET = 4'd0;
  localparam logic [3:0] MODE_SET = 4'd1;
  localparam logic [3:0] MODE_APP = 4'd2;
  localparam logic [3:0] MODE_INS = 4'd3;
  localparam logic [3:0] MODE_DEL = 4'd4;
  localparam logic [3:0] MODE_LIN = 4'd5;
  localparam logic [3:0] MODE_BIN = 4'd6;
  localparam logic [3:0] MODE_MAX = 4'd7;
  localparam logic [3:0] MODE_MIN = 4'd8;
  localparam logic [3:0] MODE_SUM = 4'd9;
  localparam logic [3:0] MODE_REV = 4'd10;

  localparam logic       REG_CAPACITY = 1'b0;
  localparam logic [8:0] CAP_RESET    = 9'd256;

  typedef struct packed {
    logic [3:0]         mode;
    logic [7:0]         index;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [39:0] result_value;
    logic [7:0]         result_index;
    logic               ok;
    logic [8:0]         count;
  } result_t;

  typedef enum logic [3:0] {
    OP_GET, OP_SET, OP_APP, OP_INS, OP_DEL, OP_LIN,
    OP_BIN, OP_MAX, OP_MIN, OP_SUM, OP_REV, OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         index;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_BS_RD, ST_BS_CMP, ST_RV_RD, ST_RV_WA, ST_RV_WB, ST_FIN
  } state_t;

endpackage

// File: src/alist_front.sv
// ----------------------------------------------------------------------------
// alist_front
// Accepts command beats, decodes the mode and queues them for the back end.
// ----------------------------------------------------------------------------
module alist_front import alist_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  item_t item,
  output logic  qvalid,
  output cmd_t  head,
  input  logic  pop
);

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       cmd;

  always_comb begin
    cmd.index = item.index;
    cmd.value = item.value;
    unique case (item.mode)
      MODE_GET: cmd.op = OP_GET;
      MODE_SET: cmd.op = OP_SET;
      MODE_APP: cmd.op = OP_APP;
      MODE_INS: cmd.op = OP_INS;
      MODE_DEL: cmd.op = OP_DEL;
      MODE_LIN: cmd.op = OP_LIN;
      MODE_BIN: cmd.op = OP_BIN;
      MODE_MAX: cmd.op = OP_MAX;
      MODE_MIN: cmd.op = OP_MIN;
      MODE_SUM: cmd.op = OP_SUM;
      MODE_REV: cmd.op = OP_REV;
      default:  cmd.op = OP_NOP;
    endcase
  end

  assign busy   = (fill == 2'd2);
  assign push   = start && !busy;
  assign qvalid = (fill != 2'd0);
  assign head   = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/alist_back.sv
// ----------------------------------------------------------------------------
// alist_back
// Executes queued commands against the element memory; scans walk one element per cycle.
// ----------------------------------------------------------------------------
module alist_back import alist_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [8:0] capacity,
  input  logic       qvalid,
  input  cmd_t       head,
  output logic       pop,
  output logic       done,
  output result_t    result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 9) ? CW : 9;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd0, rd1;
  logic [AW-1:0] ra0, ra1, wa;
  logic [31:0] wd;
  logic we;

  state_t state, state_next;
  cmd_t   cur;
  logic [CW-1:0] cnt, cnt_new;
  logic [AW-1:0] p, plast, pa, bmid, ptr_a, ptr_b, fin_wa;
  logic iss, pv, okr, fin_we;
  logic signed [39:0] rv;
  logic [7:0] ri;
  logic signed [CW:0] lo, hi;
  logic [CW+1:0] msum;
  logic [AW-1:0] mid_a;
  logic signed [39:0] e40;
  logic [XW-1:0] nx, ix, capx;
  logic g_in, g_room, g_ins;
  logic [AW:0] gap;

  assign nx     = XW'(cnt);
  assign ix     = XW'(head.index);
  assign capx   = (XW'(capacity) < XW'(DEPTH)) ? XW'(capacity) : XW'(DEPTH);
  assign g_in   = ix < nx;
  assign g_room = nx < capx;
  assign g_ins  = (ix <= nx) && g_room;
  assign msum   = {lo[CW], lo} + {hi[CW], hi};
  assign mid_a  = AW'(msum >> 1);
  assign e40    = {{8{rd0[31]}}, rd0};
  assign gap    = {1'b0, ptr_b} - {1'b0, ptr_a};
  assign pop    = (state == ST_IDLE) && qvalid;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ra0 = p;
    ra1 = ptr_b;
    we  = 1'b0;
    wa  = fin_wa;
    wd  = cur.value;
    unique case (state)
      ST_IDLE: begin
        if (qvalid) begin
          unique case (head.op)
            OP_GET, OP_DEL: state_next = g_in ? ST_SCAN : ST_FIN;
            OP_INS: state_next = (g_ins && g_in) ? ST_SCAN : ST_FIN;
            OP_LIN, OP_MAX, OP_MIN, OP_SUM:
              state_next = (cnt != '0) ? ST_SCAN : ST_FIN;
            OP_BIN: state_next = ST_BS_RD;
            OP_REV: state_next = (cnt > CW'(1)) ? ST_RV_RD : ST_FIN;
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        if (pv && cur.op == OP_INS) begin
          we = 1'b1;
          wa = pa + 1'b1;
          wd = rd0;
        end else if (pv && cur.op == OP_DEL && pa != AW'(cur.index)) begin
          we = 1'b1;
          wa = pa - 1'b1;
          wd = rd0;
        end
        if (!iss && !pv) state_next = ST_FIN;
      end
      ST_BS_RD: begin
        ra0 = mid_a;
        state_next = (lo <= hi) ? ST_BS_CMP : ST_FIN;
      end
      ST_BS_CMP: begin
        state_next = ($signed(rd0) == cur.value) ? ST_FIN : ST_BS_RD;
      end
      ST_RV_RD: begin
        ra0 = ptr_a;
        state_next = ST_RV_WA;
      end
      ST_RV_WA: begin
        // hold both read addresses so rd0 still shows the old front element
        ra0 = ptr_a;
        we  = 1'b1;
        wa  = ptr_a;
        wd  = rd1;
        state_next = ST_RV_WB;
      end
      ST_RV_WB: begin
        we = 1'b1;
        wa = ptr_b;
        wd = rd0;
        state_next = (gap > (AW+1)'(2)) ? ST_RV_RD : ST_FIN;
      end
      ST_FIN: begin
        we = fin_we;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
      iss  <= 1'b0;
      pv   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (qvalid) begin
            cur     <= head;
            rv      <= '0;
            ri      <= '0;
            okr     <= 1'b0;
            fin_we  <= 1'b0;
            fin_wa  <= AW'(head.index);
            cnt_new <= cnt;
            iss     <= (state_next == ST_SCAN);
            pv      <= 1'b0;
            p       <= '0;
            plast   <= AW'(cnt - 1'b1);
            lo      <= '0;
            hi      <= {1'b0, cnt} - 1'b1;
            ptr_a   <= '0;
            ptr_b   <= AW'(cnt - 1'b1);
            case (head.op)
              OP_GET: begin
                okr   <= g_in;
                p     <= AW'(head.index);
                plast <= AW'(head.index);
              end
              OP_SET: begin
                okr    <= g_in;
                fin_we <= g_in;
                if (g_in) rv <= 40'(head.value);
              end
              OP_APP: begin
                okr    <= g_room;
                fin_we <= g_room;
                fin_wa <= AW'(cnt);
                if (g_room) cnt_new <= cnt + 1'b1;
              end
              OP_INS: begin
                okr    <= g_ins;
                fin_we <= g_ins;
                p      <= AW'(cnt - 1'b1);
                plast  <= AW'(head.index);
                if (g_ins) cnt_new <= cnt + 1'b1;
              end
              OP_DEL: begin
                okr <= g_in;
                p   <= AW'(head.index);
                if (g_in) cnt_new <= cnt - 1'b1;
              end
              OP_MAX, OP_MIN: okr <= (cnt != '0);
              OP_SUM, OP_REV: okr <= 1'b1;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          pv <= iss;
          if (iss) begin
            pa <= p;
            if (p == plast)            iss <= 1'b0;
            else if (cur.op == OP_INS) p   <= p - 1'b1;
            else                       p   <= p + 1'b1;
          end
          if (pv) begin
            case (cur.op)
              OP_GET: rv <= e40;
              OP_DEL: if (pa == AW'(cur.index)) rv <= e40;
              OP_LIN: begin
                if (!okr && rd0 == cur.value) begin
                  okr <= 1'b1;
                  ri  <= 8'(pa);
                end
              end
              OP_MAX: if (pa == '0 || e40 > rv) rv <= e40;
              OP_MIN: if (pa == '0 || e40 < rv) rv <= e40;
              OP_SUM: rv <= rv + e40;
              default: ;
            endcase
          end
        end
        ST_BS_RD: bmid <= mid_a;
        ST_BS_CMP: begin
          if ($signed(rd0) == cur.value) begin
            okr <= 1'b1;
            ri  <= 8'(bmid);
          end else if ($signed(rd0) > cur.value) begin
            hi <= (CW+1)'(bmid) - 1'b1;
          end else begin
            lo <= (CW+1)'(bmid) + 1'b1;
          end
        end
        ST_RV_WB: begin
          ptr_a <= ptr_a + 1'b1;
          ptr_b <= ptr_b - 1'b1;
        end
        ST_FIN: begin
          cnt                 <= cnt_new;
          done                <= 1'b1;
          result.result_value <= rv;
          result.result_index <= ri;
          result.ok           <= okr;
          result.count        <= 9'(cnt_new);
        end
        default: ;
      endcase
    end
  end

endmodule

// File: src/array_list_engine_core.sv
// ----------------------------------------------------------------------------
// array_list_engine_core
// Packed list of signed 32-bit elements with get/set/append/insert/delete,
// searches, max, min, sum and reverse, one result per command.
// ----------------------------------------------------------------------------
// Element walks: get reads one element, insert/delete move n-idx elements, scans
//   read all n; binary search probes the midpoint of a shrinking range and
//   reverse swaps pairs from both ends inward.
// Throughput: one command at a time in the back end; a two-beat queue takes
//   new commands meanwhile. Results strobe one cycle; the receiver cannot stall.
// Reset (sync): count 0, capacity 256; element memory is not cleared.
module array_list_engine_core import alist_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] capacity;
  logic       qvalid;
  logic       pop;
  cmd_t       head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {23'b0, capacity} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[8:0];
    end
  end

  alist_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .qvalid (qvalid),
    .head   (head),
    .pop    (pop)
  );

  alist_back #(.DEPTH(DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .qvalid   (qvalid),
    .head     (head),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(result.count) <= DEPTH)) else $error("count beyond depth");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> (result.result_value == '0 && result.result_index == '0))
    else $error("failed result carries data");

endmodule
